// ===== design/sobel_edge_magnitude_rgb_top_defines.svh =====
// Shared assertion macros
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_TOP_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_TOP_DEFINES_SVH

// Check a property on the rising clock edge, off while in reset
`define SEM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sem assertion failed");

// Check that a condition never holds
`define SEM_ASSERT_NEVER(lbl, cond) \
  `SEM_ASSERT(lbl, !(cond))

`endif

// ===== design/sem_pkg.sv =====
package sem_pkg;

  localparam int unsigned PIX_W          = 8;
  localparam int unsigned COL_OUT_W      = 10;
  localparam int unsigned ROW_OUT_W      = 12;
  localparam int unsigned CFG_WIDTH_W    = 11;
  localparam int unsigned CFG_HEIGHT_W   = 13;
  localparam int unsigned CFG_DATA_W     = 13;
  localparam int unsigned CFG_ADDR_W     = 2;
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;
  localparam int unsigned RESET_WIDTH    = 1024;
  localparam int unsigned RESET_HEIGHT   = 768;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned GRAD_W         = 12;
  localparam int unsigned SUM_W          = 22;
  localparam int unsigned ROOT_W         = 17;
  localparam int unsigned REM_W          = 16;
  localparam int unsigned ROOT_STEPS     = 8;
  localparam int unsigned SAT_LIMIT      = 65025;
  localparam int unsigned MAG_MAX        = 255;

  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  typedef logic [PIX_W-1:0] sample_t;

  typedef struct packed {
    sample_t blue;
    sample_t green;
    sample_t red;
  } rgb_t;

  typedef struct packed {
    rgb_t [8:0]             pix;
    logic [COL_OUT_W-1:0]   column;
    logic [ROW_OUT_W-1:0]   row;
    logic                   run_last;
    logic                   frame_last;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_READ,
    F_EMIT
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SQUARE,
    B_ROOT,
    B_HOLD
  } back_state_e;

endpackage

// ===== design/sem_front.sv =====
module sem_front #(
  parameter int unsigned MaxWidth  = sem_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MaxHeight = sem_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sem_pkg::CFG_ADDR_W-1:0]  cfg_index_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  sem_pkg::rgb_t                   pixel_i,
  output sem_pkg::job_t                   job_o,
  output logic                            job_push_o,
  input  logic                            job_full_i
);

  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned RowW = $clog2(MaxHeight);
  localparam int unsigned ResetW =
    (sem_pkg::RESET_WIDTH < MaxWidth) ? sem_pkg::RESET_WIDTH : MaxWidth;
  localparam int unsigned ResetH =
    (sem_pkg::RESET_HEIGHT < MaxHeight) ? sem_pkg::RESET_HEIGHT : MaxHeight;

  sem_pkg::front_state_e state_q, state_d;

  logic [ColW-1:0] wlast_q, wlast_d, col_q, col_d;
  logic [RowW-1:0] hlast_q, hlast_d, row_q, row_d;
  logic [1:0]      k_q, k_d;
  logic [3:0]      e_q, e_d;
  logic            cfg_we, accept, advance, done;

  logic [23:0]     older_mem [MaxWidth];
  logic [23:0]     newer_mem [MaxWidth];
  sem_pkg::rgb_t   up1_q, up2_q, cur_q;
  sem_pkg::rgb_t   win_q [3][3];

  logic [ColW-1:0] oc;
  logic [RowW-1:0] orow;
  logic [1:0]      cbase, rbase;
  logic [1:0]      csel [3];
  logic [1:0]      rsel [3];
  logic            lastc, lastr;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign accept      = push && !full;
  assign lastc       = (col_q == wlast_q);
  assign lastr       = (row_q == hlast_q);

  always_comb begin
    wlast_d = wlast_q;
    hlast_d = hlast_q;
    if (cfg_we && cfg_index_i == sem_pkg::REG_IMAGE_WIDTH) begin
      if (cfg_data_i[sem_pkg::CFG_WIDTH_W-1:0] == '0) begin
        wlast_d = '0;
      end else if (32'(cfg_data_i[sem_pkg::CFG_WIDTH_W-1:0]) > 32'(MaxWidth)) begin
        wlast_d = ColW'(MaxWidth - 1);
      end else begin
        wlast_d = ColW'(cfg_data_i[sem_pkg::CFG_WIDTH_W-1:0] - 1'b1);
      end
    end
    if (cfg_we && cfg_index_i == sem_pkg::REG_IMAGE_HEIGHT) begin
      if (cfg_data_i[sem_pkg::CFG_HEIGHT_W-1:0] == '0) begin
        hlast_d = '0;
      end else if (32'(cfg_data_i[sem_pkg::CFG_HEIGHT_W-1:0]) > 32'(MaxHeight)) begin
        hlast_d = RowW'(MaxHeight - 1);
      end else begin
        hlast_d = RowW'(cfg_data_i[sem_pkg::CFG_HEIGHT_W-1:0] - 1'b1);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sem_pkg::F_IDLE: if (accept) state_d = sem_pkg::F_READ;
      sem_pkg::F_READ: state_d = sem_pkg::F_EMIT;
      sem_pkg::F_EMIT: if (done) state_d = sem_pkg::F_IDLE;
      default:         state_d = sem_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    full       = (state_q != sem_pkg::F_IDLE);
    job_push_o = (state_q == sem_pkg::F_EMIT) && e_q[k_q] && !job_full_i;
    advance    = (state_q == sem_pkg::F_EMIT) && (!e_q[k_q] || !job_full_i);
    done       = advance && (k_q == 2'd3);
    k_d        = k_q;
    e_d        = e_q;
    col_d      = col_q;
    row_d      = row_q;
    if (state_q == sem_pkg::F_READ) begin
      k_d = 2'd0;
      e_d = {lastr && lastc, lastr && (col_q != '0),
             (row_q != '0) && lastc, (row_q != '0) && (col_q != '0)};
    end else if (advance) begin
      k_d = k_q + 2'd1;
    end
    if (done) begin
      if (lastc) begin
        col_d = '0;
        row_d = lastr ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
    if (cfg_we && (cfg_index_i == sem_pkg::REG_IMAGE_WIDTH ||
                   cfg_index_i == sem_pkg::REG_IMAGE_HEIGHT)) begin
      col_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sem_pkg::F_IDLE;
      wlast_q <= ColW'(ResetW - 1);
      hlast_q <= RowW'(ResetH - 1);
      col_q   <= '0;
      row_q   <= '0;
      k_q     <= '0;
      e_q     <= '0;
    end else begin
      state_q <= state_d;
      wlast_q <= wlast_d;
      hlast_q <= hlast_d;
      col_q   <= col_d;
      row_q   <= row_d;
      k_q     <= k_d;
      e_q     <= e_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      up1_q <= newer_mem[col_q];
      up2_q <= older_mem[col_q];
      cur_q <= pixel_i;
    end
    if (state_q == sem_pkg::F_READ) begin
      older_mem[col_q] <= up1_q;
      newer_mem[col_q] <= cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win_q[c][r] <= '0;
        end
      end
    end else if (state_q == sem_pkg::F_READ) begin
      win_q[0]    <= win_q[1];
      win_q[1]    <= win_q[2];
      win_q[2][0] <= up2_q;
      win_q[2][1] <= up1_q;
      win_q[2][2] <= cur_q;
    end
  end

  always_comb begin
    oc      = k_q[0] ? col_q : col_q - 1'b1;
    orow    = k_q[1] ? row_q : row_q - 1'b1;
    cbase   = k_q[0] ? 2'd2 : 2'd1;
    rbase   = k_q[1] ? 2'd2 : 2'd1;
    csel[0] = (oc == '0) ? cbase : cbase - 2'd1;
    csel[1] = cbase;
    csel[2] = 2'd2;
    rsel[0] = (orow == '0) ? rbase : rbase - 2'd1;
    rsel[1] = rbase;
    rsel[2] = 2'd2;
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        job_o.pix[dy*3+dx] = win_q[csel[dx]][rsel[dy]];
      end
    end
    job_o.column     = sem_pkg::COL_OUT_W'(oc);
    job_o.row        = sem_pkg::ROW_OUT_W'(orow);
    job_o.frame_last = (oc == wlast_q) && (orow == hlast_q);
    case (k_q)
      2'd0:    job_o.run_last = !(|e_q[3:1]);
      2'd1:    job_o.run_last = !(|e_q[3:2]);
      2'd2:    job_o.run_last = !e_q[3];
      default: job_o.run_last = 1'b1;
    endcase
  end

endmodule

// ===== design/sem_fifo.sv =====
`include "sobel_edge_magnitude_rgb_top_defines.svh"

module sem_fifo #(
  parameter int unsigned Depth = sem_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sem_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output sem_pkg::job_t data_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sem_pkg::job_t  store_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = store_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_q] <= data_i;
    end
  end

  `SEM_ASSERT_NEVER(a_no_overflow, push_i && full_o && !pop_i)
  `SEM_ASSERT_NEVER(a_no_underflow, pop_i && empty_o)

endmodule

// ===== design/sem_back.sv =====
`include "sobel_edge_magnitude_rgb_top_defines.svh"

module sem_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sem_pkg::job_t                  job_i,
  input  logic                           job_empty_i,
  output logic                           job_pop_o,
  output sem_pkg::rgb_t                  edge_o,
  output logic [sem_pkg::COL_OUT_W-1:0]  column_o,
  output logic [sem_pkg::ROW_OUT_W-1:0]  row_o,
  output logic                           run_last_o,
  output logic                           frame_last_o,
  output logic                           empty,
  input  logic                           pop
);

  sem_pkg::back_state_e state_q, state_d;

  logic signed [sem_pkg::GRAD_W-1:0] gx_q [3];
  logic signed [sem_pkg::GRAD_W-1:0] gy_q [3];
  logic signed [sem_pkg::GRAD_W-1:0] gx_d [3];
  logic signed [sem_pkg::GRAD_W-1:0] gy_d [3];
  logic signed [sem_pkg::GRAD_W-1:0] smp  [3][9];
  logic signed [2*sem_pkg::GRAD_W-1:0] sq_x [3];
  logic signed [2*sem_pkg::GRAD_W-1:0] sq_y [3];
  logic [sem_pkg::SUM_W-1:0]  sum    [3];
  logic [sem_pkg::REM_W-1:0]  rem_q  [3];
  logic [sem_pkg::ROOT_W-1:0] root_q [3];
  logic [sem_pkg::ROOT_W-1:0] trial  [3];
  logic [sem_pkg::ROOT_W-1:0] bitv;
  logic [2:0]                 sat_q;
  logic [2:0]                 step_q;

  logic [sem_pkg::COL_OUT_W-1:0] col_q;
  logic [sem_pkg::ROW_OUT_W-1:0] row_q;
  logic run_last_q, frame_last_q;

  logic out_valid_q, out_valid_d, load_job, load_out;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int p = 0; p < 9; p++) begin
        smp[ch][p] = $signed({4'b0, job_i.pix[p][ch*sem_pkg::PIX_W +: sem_pkg::PIX_W]});
      end
      gx_d[ch] = (smp[ch][2] + (smp[ch][5] <<< 1) + smp[ch][8])
               - (smp[ch][0] + (smp[ch][3] <<< 1) + smp[ch][6]);
      gy_d[ch] = (smp[ch][6] + (smp[ch][7] <<< 1) + smp[ch][8])
               - (smp[ch][0] + (smp[ch][1] <<< 1) + smp[ch][2]);
      sq_x[ch] = gx_q[ch] * gx_q[ch];
      sq_y[ch] = gy_q[ch] * gy_q[ch];
      sum[ch]  = sq_x[ch][sem_pkg::SUM_W-1:0] + sq_y[ch][sem_pkg::SUM_W-1:0];
      trial[ch] = root_q[ch] + bitv;
    end
  end

  assign bitv = sem_pkg::ROOT_W'(1) << (2 * (3'd7 - step_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sem_pkg::B_IDLE:   if (!job_empty_i) state_d = sem_pkg::B_SQUARE;
      sem_pkg::B_SQUARE: state_d = sem_pkg::B_ROOT;
      sem_pkg::B_ROOT:   if (step_q == 3'd7) state_d = sem_pkg::B_HOLD;
      sem_pkg::B_HOLD:   if (load_out) state_d = sem_pkg::B_IDLE;
      default:           state_d = sem_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    load_job    = (state_q == sem_pkg::B_IDLE) && !job_empty_i;
    job_pop_o   = load_job;
    load_out    = (state_q == sem_pkg::B_HOLD) && (!out_valid_q || pop);
    empty       = !out_valid_q;
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sem_pkg::B_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == sem_pkg::B_SQUARE) begin
        step_q <= '0;
      end else if (state_q == sem_pkg::B_ROOT) begin
        step_q <= step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_job) begin
      gx_q         <= gx_d;
      gy_q         <= gy_d;
      col_q        <= job_i.column;
      row_q        <= job_i.row;
      run_last_q   <= job_i.run_last;
      frame_last_q <= job_i.frame_last;
    end
    for (int ch = 0; ch < 3; ch++) begin
      if (state_q == sem_pkg::B_SQUARE) begin
        rem_q[ch]  <= sum[ch][sem_pkg::REM_W-1:0];
        root_q[ch] <= '0;
        sat_q[ch]  <= (sum[ch] >= sem_pkg::SUM_W'(sem_pkg::SAT_LIMIT));
      end else if (state_q == sem_pkg::B_ROOT) begin
        if (sem_pkg::ROOT_W'(rem_q[ch]) >= trial[ch]) begin
          rem_q[ch]  <= rem_q[ch] - sem_pkg::REM_W'(trial[ch]);
          root_q[ch] <= (root_q[ch] >> 1) + bitv;
        end else begin
          root_q[ch] <= root_q[ch] >> 1;
        end
      end
    end
    if (load_out) begin
      edge_o.red   <= sat_q[0] ? sem_pkg::PIX_W'(sem_pkg::MAG_MAX)
                               : root_q[0][sem_pkg::PIX_W-1:0];
      edge_o.green <= sat_q[1] ? sem_pkg::PIX_W'(sem_pkg::MAG_MAX)
                               : root_q[1][sem_pkg::PIX_W-1:0];
      edge_o.blue  <= sat_q[2] ? sem_pkg::PIX_W'(sem_pkg::MAG_MAX)
                               : root_q[2][sem_pkg::PIX_W-1:0];
      column_o     <= col_q;
      row_o        <= row_q;
      run_last_o   <= run_last_q;
      frame_last_o <= frame_last_q;
    end
  end

  `SEM_ASSERT(a_load_shows, load_out |=> out_valid_q)
  `SEM_ASSERT_NEVER(a_pop_only_idle, job_pop_o && state_q != sem_pkg::B_IDLE)

endmodule

// ===== design/sobel_edge_magnitude_rgb_top.sv =====
// Streaming 3x3 Sobel gradient magnitude on RGB pixels in raster order, with
// edge-replicated borders; each channel gives floor(sqrt(gx^2+gy^2)) saturated
// to 255. Results lag one row and one column; the last column and last row
// flush extra results, up to four per pixel, tagged with column, row,
// run_last and frame_last. A configuration write to the width or height
// register restarts the frame. The front end takes a new pixel only after it
// has updated its single-port line stores and stepped through every possible
// result slot. The back end takes a new result only when done with the last:
// a square step, the eight-step square-root iteration on one step counter
// shared by the three channels, and an output hold. A four-entry queue lets
// either side stall alone. No clearing pass is needed after reset.
module sobel_edge_magnitude_rgb_top #(
  parameter int unsigned MaxWidth  = sem_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MaxHeight = sem_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sem_pkg::CFG_ADDR_W-1:0]  cfg_index_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  logic [sem_pkg::PIX_W-1:0]       pixel_red_i,
  input  logic [sem_pkg::PIX_W-1:0]       pixel_green_i,
  input  logic [sem_pkg::PIX_W-1:0]       pixel_blue_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [sem_pkg::PIX_W-1:0]       edge_red_o,
  output logic [sem_pkg::PIX_W-1:0]       edge_green_o,
  output logic [sem_pkg::PIX_W-1:0]       edge_blue_o,
  output logic [sem_pkg::COL_OUT_W-1:0]   out_column_o,
  output logic [sem_pkg::ROW_OUT_W-1:0]   out_row_o,
  output logic                            run_last_o,
  output logic                            frame_last_o
);

  sem_pkg::rgb_t pixel, edge_px;
  sem_pkg::job_t job_in, job_out;
  logic          q_push, q_full, q_pop, q_empty;

  assign pixel.red    = pixel_red_i;
  assign pixel.green  = pixel_green_i;
  assign pixel.blue   = pixel_blue_i;
  assign edge_red_o   = edge_px.red;
  assign edge_green_o = edge_px.green;
  assign edge_blue_o  = edge_px.blue;

  sem_front #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .pixel_i     (pixel),
    .job_o       (job_in),
    .job_push_o  (q_push),
    .job_full_i  (q_full)
  );

  sem_fifo #(
    .Depth (sem_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (job_out),
    .empty_o (q_empty)
  );

  sem_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (job_out),
    .job_empty_i  (q_empty),
    .job_pop_o    (q_pop),
    .edge_o       (edge_px),
    .column_o     (out_column_o),
    .row_o        (out_row_o),
    .run_last_o   (run_last_o),
    .frame_last_o (frame_last_o),
    .empty        (empty),
    .pop          (pop)
  );

endmodule

// ===== test/tb.sv =====
module tb;
  import sem_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 200;
  localparam int PIXEL_CAP = 440;

  typedef struct packed {
    logic [PIX_W-1:0]     red;
    logic [PIX_W-1:0]     green;
    logic [PIX_W-1:0]     blue;
    logic [COL_OUT_W-1:0] column;
    logic [ROW_OUT_W-1:0] row;
    logic                 run_last;
    logic                 frame_last;
  } edge_pix_t;

  class sobel_board;
    edge_pix_t pending[$];
    rgb_t      upper_line[MAX_WIDTH_DEF];
    rgb_t      top_line[MAX_WIDTH_DEF];
    rgb_t      win[9];
    int        col_pos, row_pos;
    int        width_reg, height_reg;
    int        mismatches;

    function void clear();
      pending.delete();
      foreach (win[i]) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      width_reg = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_IMAGE_WIDTH) begin
        width_reg = data[CFG_WIDTH_W-1:0];
      end else if (idx == REG_IMAGE_HEIGHT) begin
        height_reg = data[CFG_HEIGHT_W-1:0];
      end else begin
        return;
      end
      col_pos = 0;
      row_pos = 0;
    endfunction

    function int clip(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function logic [PIX_W-1:0] magnitude(int gx, int gy);
      int s, root, t;
      s = gx * gx + gy * gy;
      if (s >= SAT_LIMIT) return PIX_W'(MAG_MAX);
      root = 0;
      for (int b = 7; b >= 0; b--) begin
        t = root | (1 << b);
        if (t * t <= s) root = t;
      end
      return PIX_W'(root);
    endfunction

    function void predict(int oc, int orow, int c, int r, int w, int h);
      int gx[3], gy[3];
      int cc, rr, wc, wr, kx, ky;
      rgb_t px;
      edge_pix_t e;
      gx = '{0, 0, 0};
      gy = '{0, 0, 0};
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          cc = clip(oc + dx, 0, w - 1);
          rr = clip(orow + dy, 0, h - 1);
          wc = clip(cc - c + 2, 0, 2);
          wr = clip(rr - r + 2, 0, 2);
          px = win[wc * 3 + wr];
          kx = dx * (dy == 0 ? 2 : 1);
          ky = dy * (dx == 0 ? 2 : 1);
          gx[0] += kx * px.red;   gy[0] += ky * px.red;
          gx[1] += kx * px.green; gy[1] += ky * px.green;
          gx[2] += kx * px.blue;  gy[2] += ky * px.blue;
        end
      end
      e.red = magnitude(gx[0], gy[0]);
      e.green = magnitude(gx[1], gy[1]);
      e.blue = magnitude(gx[2], gy[2]);
      e.column = COL_OUT_W'(oc);
      e.row = ROW_OUT_W'(orow);
      e.run_last = 1'b0;
      e.frame_last = (oc == w - 1) && (orow == h - 1);
      pending.push_back(e);
    endfunction

    function void note_pixel(rgb_t cur);
      int w, h, c, r, base_cnt;
      rgb_t up1, up2;
      bit lastc, lastr;
      w = clip(width_reg, 1, MAX_WIDTH_DEF);
      h = clip(height_reg, 1, MAX_HEIGHT_DEF);
      c = col_pos >= w ? 0 : col_pos;
      r = row_pos >= h ? 0 : row_pos;
      up1 = upper_line[c];
      up2 = top_line[c];
      top_line[c] = up1;
      upper_line[c] = cur;
      for (int i = 0; i < 6; i++) win[i] = win[i + 3];
      win[6] = up2;
      win[7] = up1;
      win[8] = cur;
      lastc = (c == w - 1);
      lastr = (r == h - 1);
      base_cnt = pending.size();
      if (r >= 1) begin
        if (c >= 1) predict(c - 1, r - 1, c, r, w, h);
        if (lastc) predict(c, r - 1, c, r, w, h);
      end
      if (lastr) begin
        if (c >= 1) predict(c - 1, r, c, r, w, h);
        if (lastc) predict(c, r, c, r, w, h);
      end
      if (pending.size() > base_cnt) pending[pending.size() - 1].run_last = 1'b1;
      if (lastc) begin
        col_pos = 0;
        row_pos = lastr ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
        row_pos = r;
      end
    endfunction

    function void check_edge(edge_pix_t got);
      edge_pix_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result col %0d row %0d", got.column, got.row);
        return;
      end
      want = pending.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.column !== want.column || got.row !== want.row ||
          got.run_last !== want.run_last || got.frame_last !== want.frame_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp rgb %0d/%0d/%0d c%0d r%0d rl%0b fl%0b, ",
                    "got rgb %0d/%0d/%0d c%0d r%0d rl%0b fl%0b"},
                   want.red, want.green, want.blue, want.column, want.row,
                   want.run_last, want.frame_last, got.red, got.green, got.blue,
                   got.column, got.row, got.run_last, got.frame_last);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic [PIX_W-1:0]      pixel_red_i = '0;
  logic [PIX_W-1:0]      pixel_green_i = '0;
  logic [PIX_W-1:0]      pixel_blue_i = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [PIX_W-1:0]      edge_red_o, edge_green_o, edge_blue_o;
  logic [COL_OUT_W-1:0]  out_column_o;
  logic [ROW_OUT_W-1:0]  out_row_o;
  logic                  run_last_o, frame_last_o;

  sobel_board sb;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int cycles = 0;
  int pixels_sent = 0;

  sobel_edge_magnitude_rgb_top u_top (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty)
      sb.check_edge('{edge_red_o, edge_green_o, edge_blue_o, out_column_o, out_row_o,
                      run_last_o, frame_last_o});
    if (hold_req && hold_cnt == 0) begin
      hold_cnt = 300;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      pop <= 1'b0;
    end else begin
      pop <= rst_ni && (no_idle || $urandom_range(99) >= 36);
    end
  end

  task automatic write_cfg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
    if (!no_idle && $urandom_range(99) < 36) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    push <= 1'b1;
    pixel_red_i <= r;
    pixel_green_i <= g;
    pixel_blue_i <= b;
    do @(posedge clk_i); while (full);
    sb.note_pixel('{blue: b, green: g, red: r});
    pixels_sent++;
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++)
      send_pixel(PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)),
                 PIX_W'($urandom_range(255)));
    push <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic new_frame(int w, int h);
    write_cfg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_cfg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
  endtask

  initial begin
    int w, h, n, phase;
    sb = new();
    sb.clear();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    new_frame(3, 3);
    for (int i = 0; i < 9; i++)
      send_pixel((i % 2) ? 8'hFF : 8'h00, (i < 3) ? 8'hFF : 8'h00, (i % 3 == 2) ? 8'hFF : 8'h00);
    push <= 1'b0;
    drain();
    new_frame(1, 1);
    send_pixel(8'hFF, 8'h00, 8'hAA);
    push <= 1'b0;
    drain();
    new_frame(1, 4);
    send_random(4);
    drain();
    new_frame(4, 1);
    send_random(4);
    drain();
    new_frame(0, 0);
    send_random(1);
    drain();
    write_cfg(REG_IMAGE_WIDTH, 13'h1FFF);
    write_cfg(REG_IMAGE_HEIGHT, 13'h1FFF);
    send_random(6);
    drain();
    write_cfg(REG_SPARE_A, 13'h0555);
    write_cfg(REG_SPARE_B, 13'h1AAA);
    send_random(6);
    drain();

    phase = 0;
    while (pixels_sent < 410) begin
      if ($urandom_range(9) == 0) w = $urandom_range(10, 40);
      else w = $urandom_range(1, 9);
      h = $urandom_range(1, 6);
      if (phase == 2) begin
        w = 8;
        h = 6;
        hold_req = 1'b1;
      end
      if (w * h > PIXEL_CAP - pixels_sent) begin
        if (w > PIXEL_CAP - pixels_sent) w = PIXEL_CAP - pixels_sent;
        h = (PIXEL_CAP - pixels_sent) / w;
      end
      no_idle = (phase >= 5 && phase < 8);
      new_frame(w, h);
      n = w * h;
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(1, n);
        send_random(n);
        drain();
        write_cfg(REG_SPARE_A, CFG_DATA_W'($urandom_range(8191)));
        n = w * h - n;
      end
      send_random(n);
      drain();
      phase++;
    end
    no_idle = 1'b0;

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/sem_pkg.sv
design/sem_front.sv
design/sem_fifo.sv
design/sem_back.sv
design/sobel_edge_magnitude_rgb_top.sv
test/tb.sv
